// ----- design/rbgs_pkg.sv -----
// rbgs_pkg: shared types and constants of the red-black gauss-seidel poisson solver
// used by the controller, the datapath and the top level; depends on nothing

package rbgs_pkg;

  typedef logic [5:0] coord_t;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_SOLVE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [1:0] CFG_GRID_SIZE = 2'd0;
  localparam logic [1:0] CFG_H_SQUARED = 2'd1;
  localparam logic [1:0] CFG_SHIFT     = 2'd2;
  localparam logic [1:0] CFG_MAX_ITER  = 2'd3;

  localparam logic [5:0]  GRID_SIZE_RST = 6'd10;
  localparam logic [24:0] H_SQUARED_RST = 25'd138655;
  localparam logic [5:0]  SHIFT_RST     = 6'd40;
  localparam logic [15:0] MAX_ITER_RST  = 16'd5000;

  localparam logic [61:0] RES_MAX = {62{1'b1}};

  localparam logic [2:0] STEP_LAST = 3'd7;
  localparam logic [2:0] STEP_WB   = 3'd5;

  typedef enum logic [1:0] {
    PASS_RED,
    PASS_BLACK,
    PASS_RES
  } pass_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_SOLVE,
    ST_SWEEP,
    ST_POINT,
    ST_CHECK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic     wr_point;
    logic     rd_point;
    logic     solve_init;
    logic     sweep_init;
    logic     point_en;
    logic     sweep_done;
    logic     load_out;
    pass_t    pass;
    logic [2:0] step;
    coord_t   row;
    coord_t   col;
  } cmd_t;

  typedef struct packed {
    coord_t n_act;
    logic   max_zero;
    logic   sweep_conv;
    logic   sweep_last;
    logic   out_free;
  } status_t;

endpackage

// ----- design/rbgs_ctrl.sv -----
// rbgs_ctrl: request sequencer, walks passes, points and per-point steps of a solve
// depends on rbgs_pkg; drives the datapath by cmd_t and reads status_t

module rbgs_ctrl import rbgs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [1:0] req_type,
  input  status_t    status,
  output logic       idle,
  output cmd_t       cmd
);

  state_t     state, state_next;
  pass_t      pass, pass_next;
  logic [2:0] step, step_next;
  coord_t     row, row_next;
  coord_t     col, col_next;

  logic skip;
  logic col_more, row_more;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pass  <= PASS_RED;
      step  <= '0;
      row   <= 6'd1;
      col   <= 6'd1;
    end else begin
      state <= state_next;
      pass  <= pass_next;
      step  <= step_next;
      row   <= row_next;
      col   <= col_next;
    end
  end

  assign skip     = (pass != PASS_RES) && ((row[0] ^ col[0]) != (pass == PASS_BLACK));
  assign col_more = (col + 6'd1) < status.n_act;
  assign row_more = (row + 6'd1) < status.n_act;
  assign idle     = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    pass_next  = pass;
    step_next  = step;
    row_next   = row;
    col_next   = col;
    cmd        = '0;
    cmd.pass   = pass;
    cmd.step   = step;
    cmd.row    = row;
    cmd.col    = col;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_WRITE: state_next = ST_WRITE;
            REQ_SOLVE: state_next = ST_SOLVE;
            REQ_READ:  state_next = ST_READ;
            default:   state_next = ST_FINISH;
          endcase
        end
      end
      ST_WRITE: begin
        cmd.wr_point = 1'b1;
        state_next   = ST_FINISH;
      end
      ST_READ: begin
        cmd.rd_point = 1'b1;
        state_next   = ST_FINISH;
      end
      ST_SOLVE: begin
        cmd.solve_init = 1'b1;
        state_next     = status.max_zero ? ST_FINISH : ST_SWEEP;
      end
      ST_SWEEP: begin
        cmd.sweep_init = 1'b1;
        pass_next      = PASS_RED;
        step_next      = '0;
        row_next       = 6'd1;
        col_next       = 6'd1;
        state_next     = (status.n_act < 6'd2) ? ST_CHECK : ST_POINT;
      end
      ST_POINT: begin
        cmd.point_en = !skip;
        if (skip || step == STEP_LAST) begin
          step_next = '0;
          if (col_more) begin
            col_next = col + 6'd1;
          end else if (row_more) begin
            row_next = row + 6'd1;
            col_next = 6'd1;
          end else begin
            row_next = 6'd1;
            col_next = 6'd1;
            case (pass)
              PASS_RED:   pass_next = PASS_BLACK;
              PASS_BLACK: pass_next = PASS_RES;
              default:    state_next = ST_CHECK;
            endcase
          end
        end else begin
          step_next = step + 3'd1;
        end
      end
      ST_CHECK: begin
        cmd.sweep_done = 1'b1;
        state_next = (status.sweep_conv || status.sweep_last) ? ST_FINISH : ST_SWEEP;
      end
      ST_FINISH: begin
        cmd.load_out = status.out_free;
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- design/rbgs_datapath.sv -----
// rbgs_datapath: configuration, grid memories, point arithmetic, residual and result register
// depends on rbgs_pkg; steered by rbgs_ctrl through cmd_t

module rbgs_datapath import rbgs_pkg::*; #(
  parameter int MAX_GRID   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [24:0]   cfg_data,
  input  logic          accept,
  input  logic [79:0]   in_data,
  input  logic [1:0]    in_type,
  input  cmd_t          cmd,
  output status_t       status,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [111:0]  m_tdata
);

  localparam int SIDE  = MAX_GRID + 1;
  localparam int CELLS = SIDE * SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam logic signed [63:0] VMAX = (64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;

  function automatic logic [VALUE_BITS-1:0] sat_val(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v > VMAX) ? VMAX : ((v < VMIN) ? VMIN : v);
    return r[VALUE_BITS-1:0];
  endfunction

  logic [5:0]  grid_size;
  logic [24:0] h_squared;
  logic [5:0]  reduction_shift;
  logic [15:0] max_iterations;

  logic [1:0]  req_type;
  coord_t      req_row, req_col;
  logic [31:0] req_src, req_init;

  logic [VALUE_BITS-1:0] sol_mem [CELLS];
  logic [VALUE_BITS-1:0] src_mem [CELLS];
  logic [VALUE_BITS-1:0] sol_q, src_q;

  logic                  in_grid;
  logic [AW-1:0]         req_addr, pt_addr, ctr_addr, sol_wa, sol_ra;
  logic                  sol_we, sol_re, src_we, src_re;
  logic [VALUE_BITS-1:0] sol_wd, upd_val;
  coord_t                ar, ac;

  logic signed [47:0] f48;
  logic signed [49:0] prod_hi;
  logic [48:0]        prod_lo;
  logic signed [63:0] term, nsum, sol_sx, t, e, mag;
  logic               mag_big;
  logic [30:0]        mag_lo;
  logic [61:0]        sq, acc, first_res, last_res, first_eff;
  logic [62:0]        acc_sum;
  logic [15:0]        sweeps;
  logic               conv;
  logic [63:0]        pv_full;
  logic [31:0]        pv;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size       <= GRID_SIZE_RST;
      h_squared       <= H_SQUARED_RST;
      reduction_shift <= SHIFT_RST;
      max_iterations  <= MAX_ITER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_SIZE: grid_size       <= cfg_data[5:0];
        CFG_H_SQUARED: h_squared       <= cfg_data;
        CFG_SHIFT:     reduction_shift <= cfg_data[5:0];
        CFG_MAX_ITER:  max_iterations  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_type <= in_type;
      req_row  <= in_data[5:0];
      req_col  <= in_data[11:6];
      req_src  <= in_data[43:12];
      req_init <= in_data[75:44];
    end
  end

  assign in_grid  = (32'(req_row) <= MAX_GRID) && (32'(req_col) <= MAX_GRID);
  assign req_addr = AW'(32'(req_row) * SIDE + 32'(req_col));
  assign ctr_addr = AW'(32'(cmd.row) * SIDE + 32'(cmd.col));

  always_comb begin
    ar = cmd.row;
    ac = cmd.col;
    case (cmd.step)
      3'd0:    ar = cmd.row - 6'd1;
      3'd1:    ar = cmd.row + 6'd1;
      3'd2:    ac = cmd.col - 6'd1;
      3'd3:    ac = cmd.col + 6'd1;
      default: ;
    endcase
  end
  assign pt_addr = AW'(32'(ar) * SIDE + 32'(ac));

  assign sol_we = (cmd.wr_point && in_grid) ||
                  (cmd.point_en && cmd.step == STEP_WB && cmd.pass != PASS_RES);
  assign sol_wa = cmd.wr_point ? req_addr : ctr_addr;
  assign sol_wd = cmd.wr_point ? sat_val(64'($signed(req_init))) : upd_val;
  assign sol_re = cmd.rd_point || (cmd.point_en && cmd.step <= 3'd4);
  assign sol_ra = cmd.rd_point ? req_addr : pt_addr;
  assign src_we = cmd.wr_point && in_grid;
  assign src_re = cmd.point_en && cmd.step == 3'd0;

  always_ff @(posedge clk) begin
    if (sol_we) begin
      sol_mem[sol_wa] <= sol_wd;
    end
    if (sol_re) begin
      sol_q <= sol_mem[sol_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (src_we) begin
      src_mem[req_addr] <= sat_val(64'($signed(req_src)));
    end
    if (src_re) begin
      src_q <= src_mem[ctr_addr];
    end
  end

  // source term floor(h^2 * f / 2^24) in two partial products
  assign f48     = 48'($signed(src_q));
  assign sol_sx  = 64'($signed(sol_q));
  assign t       = term + nsum;
  assign upd_val = sat_val(t >>> 2);
  assign e       = t - (sol_sx <<< 2);
  assign mag     = e[63] ? -e : e;
  assign acc_sum = {1'b0, acc} + {1'b0, sq};

  always_ff @(posedge clk) begin
    if (cmd.point_en) begin
      case (cmd.step)
        3'd1: begin
          nsum    <= sol_sx;
          prod_hi <= $signed({1'b0, h_squared}) * $signed(f48[47:24]);
        end
        3'd2: begin
          nsum    <= nsum + sol_sx;
          prod_lo <= h_squared * f48[23:0];
        end
        3'd3: begin
          nsum <= nsum + sol_sx;
          term <= 64'(prod_hi) + $signed({39'd0, prod_lo[48:24]});
        end
        3'd4: nsum <= nsum + sol_sx;
        3'd5: begin
          mag_big <= |mag[63:31];
          mag_lo  <= mag[30:0];
        end
        3'd6: sq <= mag_big ? RES_MAX : 62'(mag_lo * mag_lo);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_init) begin
      acc <= '0;
    end else if (cmd.point_en && cmd.step == STEP_LAST && cmd.pass == PASS_RES) begin
      acc <= (acc_sum > {1'b0, RES_MAX}) ? RES_MAX : acc_sum[61:0];
    end
  end

  assign first_eff = (sweeps == 16'd0) ? acc : first_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_res <= '0;
      last_res  <= '0;
      sweeps    <= '0;
      conv      <= 1'b0;
    end else if (cmd.solve_init) begin
      last_res <= '0;
      sweeps   <= '0;
      conv     <= 1'b0;
    end else if (cmd.sweep_done) begin
      first_res <= first_eff;
      last_res  <= acc;
      sweeps    <= sweeps + 16'd1;
      conv      <= status.sweep_conv;
    end
  end

  always_comb begin
    status.n_act      = (32'(grid_size) > MAX_GRID) ? 6'(MAX_GRID) : grid_size;
    status.max_zero   = (max_iterations == 16'd0);
    status.sweep_conv = acc <= (first_eff >> reduction_shift);
    status.sweep_last = (sweeps + 16'd1) == max_iterations;
    status.out_free   = !m_tvalid || m_tready;
  end

  assign pv_full = 64'($signed(sol_q));
  assign pv      = (req_type == REQ_READ && in_grid) ? pv_full[31:0] : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {1'b0, last_res, conv, sweeps, pv};
    end
  end

endmodule

// ----- design/red_black_gauss_seidel_poisson.sv -----
// red_black_gauss_seidel_poisson: top level of the 2d poisson solver
// depends on rbgs_pkg, rbgs_ctrl and rbgs_datapath
//
// requests enter on the s_ stream: tuser is the request kind (write, solve, read),
// tdata carries the point address and its source and initial values. every
// request gives exactly one result on the m_ stream with the point value read,
// the sweep count, the converged flag and the squared residual of the last solve.
// configuration is written through cfg_we/cfg_index/cfg_data; the user must write it
// only while idle; the block itself does not enforce this. a write or a read passes
// its write or read state, then the finish state loads its result; a new request is
// taken only back in idle. a solve has a setup state and then walks, sweep by sweep,
// the interior points one at a time through one solution memory port: a sweep runs
// a red, a black and a residual pass, each point of the pass color or of the residual
// pass taking steps 0 to 7 and each point of the other color skipped, then a check.
// one request is worked on at a time; a new one is taken while the last result
// still waits in the output register, but its own result is held back until
// that register is free, so a stalled receiver stops the block after one request.
// reset returns the configuration to its defaults and clears the solve status;
// the grid memories keep their contents and need no clearing.

module red_black_gauss_seidel_poisson import rbgs_pkg::*; #(
  parameter int MAX_GRID   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [24:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [79:0]  s_tdata,   // row, col, source_value, initial_value, zero pad
  input  logic [1:0]   s_tuser,   // req_type
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata    // point_value, iterations_done, converged,
                                  // residual_squared, zero pad
);

  cmd_t    cmd;
  status_t status;
  logic    accept;

  assign accept = s_tvalid && s_tready;

  rbgs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .req_type (s_tuser),
    .status   (status),
    .idle     (s_tready),
    .cmd      (cmd)
  );

  rbgs_datapath #(
    .MAX_GRID   (MAX_GRID),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_data   (s_tdata),
    .in_type   (s_tuser),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// ----- design/rbgs_checker.sv -----
// rbgs_checker: port-level checks of the poisson solver, bound to the top level
// depends on red_black_gauss_seidel_poisson port names only

module rbgs_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [111:0] m_tdata
);

  // result register empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  // converged needs at least one sweep
  a_conv_sweeps: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[48] |-> m_tdata[47:32] != 16'd0)
    else $error("converged with no sweep");

endmodule

bind red_black_gauss_seidel_poisson rbgs_checker u_rbgs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
